/* rtl/imu_fifo_gyro_accel_pairer_defines.svh */
// Assertion macros shared by the pairer RTL files.
// Depends on nothing; included by the modules that carry assertions.
`ifndef IMU_FIFO_GYRO_ACCEL_PAIRER_DEFINES_SVH
`define IMU_FIFO_GYRO_ACCEL_PAIRER_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define IFGAP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define IFGAP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/ifgap_pkg.sv */
// Types and constants of the gyro and accelerometer pairer.
// Depends on nothing; imported by every module of the block.
`default_nettype none
package ifgap_pkg;

  typedef enum logic [1:0] {
    OP_FIFO_WORD = 2'd0,
    OP_STATUS    = 2'd1,
    OP_DIAG      = 2'd2,
    OP_RESTART   = 2'd3
  } ifgap_op_t;

  localparam int TAG_LSB = 3;
  localparam int TAG_W = 5;
  localparam int PADDR_W = 3;
  localparam logic REG_GYRO_TAG = 1'b0;
  localparam logic REG_ACCEL_TAG = 1'b1;
  localparam logic [TAG_W-1:0] GYRO_TAG_RESET = 5'd1;
  localparam logic [TAG_W-1:0] ACCEL_TAG_RESET = 5'd2;
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_DIAG = 1'b1;

  typedef struct packed {
    ifgap_op_t          opcode;
    logic [1:0]         channel;
    logic [7:0]         tag_byte;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic               overrun_bit;
  } ifgap_in_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic               stale_gyro;
    logic [31:0]        reuse_total;
    logic [31:0]        unknown_total;
    logic               overrun_seen;
  } ifgap_out_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } ifgap_gyro_t;

  typedef struct packed {
    logic [31:0] reuse;
    logic [31:0] unknown;
    logic        overrun;
  } ifgap_diag_t;

  typedef struct packed {
    logic [TAG_W-1:0] gyro_tag;
    logic [TAG_W-1:0] accel_tag;
  } ifgap_cfg_t;

  typedef struct packed {
    logic        gyro_en;
    logic        diag_en;
    ifgap_gyro_t gyro;
    ifgap_diag_t diag;
  } ifgap_wr_t;

endpackage
`default_nettype wire

/* rtl/imu_fifo_gyro_accel_pairer.sv */
// Top level of the gyro and accelerometer pairer: two-stage read-modify-write pipeline
// over the state memories. Depends on ifgap_pkg, ifgap_cfg, ifgap_store and the defines.
//
//   channel   direction  handshake                  payload
//   item      in         item_valid / item_stall    ifgap_in_t
//   result    out        result_valid / result_stall ifgap_out_t
//   config    in         psel / penable / pwrite    paddr, pwdata, prdata
//
// One item per cycle is accepted while item_stall is low. Diagnostic reads and paired
// accelerometer words yield a result: first-stage memory read, then the result register.
// Counter entries are marked empty by flip-flops at reset.
// A stalled result holds both stages; items stall in the same cycle only if the first stage is also full.
`default_nettype none
module imu_fifo_gyro_accel_pairer #(
  parameter int CHANNELS = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire ifgap_pkg::ifgap_in_t          item,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output ifgap_pkg::ifgap_out_t              result,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ifgap_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import ifgap_pkg::*;
  `include "imu_fifo_gyro_accel_pairer_defines.svh"

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  ifgap_cfg_t cfg;
  ifgap_gyro_t gyro_q;
  ifgap_diag_t diag_q;
  ifgap_wr_t wr;
  logic accept;
  logic item_ok;
  logic [IDX_W-1:0] item_addr;
  logic s1_valid;
  logic s1_ok;
  logic [IDX_W-1:0] s1_addr;
  ifgap_in_t s1_item;
  logic s1_go;
  logic [TAG_W-1:0] s1_tag;
  logic [CHANNELS-1:0] present;
  logic [CHANNELS-1:0] fresh;
  logic present_next;
  logic fresh_next;
  logic res_en;
  ifgap_out_t res;

  ifgap_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ifgap_store #(.CHANNELS(CHANNELS)) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept && item_ok),
    .rd_addr (item_addr),
    .wr      (wr),
    .wr_addr (s1_addr),
    .gyro_q  (gyro_q),
    .diag_q  (diag_q)
  );

  assign item_stall = s1_valid && result_valid && result_stall;
  assign accept = item_valid && !item_stall;
  assign item_ok = 32'(item.channel) < CHANNELS;
  assign item_addr = IDX_W'(item.channel);
  assign s1_go = s1_valid && !(result_valid && result_stall);
  assign s1_tag = s1_item.tag_byte[TAG_LSB +: TAG_W];

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= item;
      s1_ok <= item_ok;
      s1_addr <= item_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_comb begin
    wr = '0;
    res = '0;
    res_en = 1'b0;
    present_next = s1_ok ? present[s1_addr] : 1'b0;
    fresh_next = s1_ok ? fresh[s1_addr] : 1'b0;
    unique case (s1_item.opcode)
      OP_DIAG: begin
        res_en = 1'b1;
        res.result_kind = KIND_DIAG;
        if (s1_ok) begin
          res.reuse_total = diag_q.reuse;
          res.unknown_total = diag_q.unknown;
          res.overrun_seen = diag_q.overrun;
          wr.diag_en = 1'b1;
        end
      end
      OP_STATUS: begin
        if (s1_ok && s1_item.overrun_bit) begin
          wr.diag_en = 1'b1;
          wr.diag = diag_q;
          wr.diag.overrun = 1'b1;
        end
      end
      OP_RESTART: begin
        present_next = 1'b0;
        fresh_next = 1'b0;
      end
      OP_FIFO_WORD: begin
        if (s1_ok) begin
          if (s1_tag == cfg.gyro_tag) begin
            wr.gyro_en = 1'b1;
            wr.gyro.x = s1_item.axis_x;
            wr.gyro.y = s1_item.axis_y;
            wr.gyro.z = s1_item.axis_z;
            present_next = 1'b1;
            fresh_next = 1'b1;
          end else if (s1_tag == cfg.accel_tag) begin
            if (present[s1_addr]) begin
              res_en = 1'b1;
              res.result_kind = KIND_SAMPLE;
              res.gyro_x = gyro_q.x;
              res.gyro_y = gyro_q.y;
              res.gyro_z = gyro_q.z;
              res.accel_x = s1_item.axis_x;
              res.accel_y = s1_item.axis_y;
              res.accel_z = s1_item.axis_z;
              res.stale_gyro = !fresh[s1_addr];
              fresh_next = 1'b0;
              if (!fresh[s1_addr]) begin
                wr.diag_en = 1'b1;
                wr.diag = diag_q;
                wr.diag.reuse = diag_q.reuse + 32'd1;
              end
            end
          end else begin
            wr.diag_en = 1'b1;
            wr.diag = diag_q;
            wr.diag.unknown = diag_q.unknown + 32'd1;
          end
        end
      end
      default: ;
    endcase
    wr.gyro_en = wr.gyro_en && s1_go;
    wr.diag_en = wr.diag_en && s1_go;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
      fresh <= '0;
    end else if (s1_go && s1_ok) begin
      present[s1_addr] <= present_next;
      fresh[s1_addr] <= fresh_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && res_en) begin
      result <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_go && res_en) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  `IFGAP_ASSERT_NEXT(a_gyro_marks, clk, rst,
    s1_go && s1_ok && (s1_item.opcode == OP_FIFO_WORD) && (s1_tag == cfg.gyro_tag),
    present[$past(s1_addr)] && fresh[$past(s1_addr)], "Gyro word did not mark the channel.")
  `IFGAP_ASSERT_NEXT(a_sample_unfresh, clk, rst,
    s1_go && s1_ok && res_en && (res.result_kind == KIND_SAMPLE),
    !fresh[$past(s1_addr)], "Paired gyro is still marked fresh.")
  `IFGAP_ASSERT_NEXT(a_restart_clears, clk, rst,
    s1_go && s1_ok && (s1_item.opcode == OP_RESTART),
    !present[$past(s1_addr)] && !fresh[$past(s1_addr)], "Restart left pairing state set.")

endmodule
`default_nettype wire

/* rtl/ifgap_cfg.sv */
// APB-style register file holding the gyro and accelerometer tag codes.
// Depends on ifgap_pkg.
`default_nettype none
module ifgap_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ifgap_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  output ifgap_pkg::ifgap_cfg_t              cfg
);
  import ifgap_pkg::*;

  logic wr_en;

  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gyro_tag <= GYRO_TAG_RESET;
      cfg.accel_tag <= ACCEL_TAG_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_GYRO_TAG:  cfg.gyro_tag <= pwdata[TAG_W-1:0];
        REG_ACCEL_TAG: cfg.accel_tag <= pwdata[TAG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_GYRO_TAG:  prdata = 32'(cfg.gyro_tag);
      REG_ACCEL_TAG: prdata = 32'(cfg.accel_tag);
      default:       prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/ifgap_store.sv */
// Per-channel state memories (pending gyro, counters and overrun latch) with registered
// reads and write forwarding. Depends on ifgap_pkg and the defines.
`default_nettype none
module ifgap_store #(
  parameter int CHANNELS = 4,
  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   rd_en,
  input  wire logic [IDX_W-1:0]       rd_addr,
  input  wire ifgap_pkg::ifgap_wr_t   wr,
  input  wire logic [IDX_W-1:0]       wr_addr,
  output ifgap_pkg::ifgap_gyro_t      gyro_q,
  output ifgap_pkg::ifgap_diag_t      diag_q
);
  import ifgap_pkg::*;
  `include "imu_fifo_gyro_accel_pairer_defines.svh"

  ifgap_gyro_t gyro_mem [CHANNELS];
  ifgap_diag_t diag_mem [CHANNELS];
  logic [CHANNELS-1:0] diag_ok;
  ifgap_gyro_t gyro_rd;
  ifgap_diag_t diag_rd;
  logic diag_ok_rd;
  logic gyro_hit;
  logic diag_hit;
  ifgap_gyro_t fwd_gyro;
  ifgap_diag_t fwd_diag;

  always_ff @(posedge clk) begin
    if (wr.gyro_en) begin
      gyro_mem[wr_addr] <= wr.gyro;
    end
    if (wr.diag_en) begin
      diag_mem[wr_addr] <= wr.diag;
    end
    if (rd_en) begin
      gyro_rd <= gyro_mem[rd_addr];
      diag_rd <= diag_mem[rd_addr];
      fwd_gyro <= wr.gyro;
      fwd_diag <= wr.diag;
    end
  end

  // A counter entry that was never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      diag_ok <= '0;
      diag_ok_rd <= 1'b0;
      gyro_hit <= 1'b0;
      diag_hit <= 1'b0;
    end else begin
      if (wr.diag_en) begin
        diag_ok[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        diag_ok_rd <= diag_ok[rd_addr];
        gyro_hit <= wr.gyro_en && (wr_addr == rd_addr);
        diag_hit <= wr.diag_en && (wr_addr == rd_addr);
      end
    end
  end

  assign gyro_q = gyro_hit ? fwd_gyro : gyro_rd;
  assign diag_q = diag_hit ? fwd_diag : (diag_ok_rd ? diag_rd : '0);

  `IFGAP_ASSERT_NEXT(a_gyro_fwd, clk, rst, rd_en && wr.gyro_en && (wr_addr == rd_addr),
    gyro_q == $past(wr.gyro), "Gyro write was not forwarded to a colliding read.")
  `IFGAP_ASSERT_NEXT(a_diag_fwd, clk, rst, rd_en && wr.diag_en && (wr_addr == rd_addr),
    diag_q == $past(wr.diag), "Counter write was not forwarded to a colliding read.")
  `IFGAP_ASSERT_NEXT(a_diag_ok, clk, rst, wr.diag_en,
    diag_ok[$past(wr_addr)], "Written counter entry is not marked valid.")

endmodule
`default_nettype wire
